/* hw/rtl/fpa_pkg.sv */
// Shared constants and types for the fixed-point ALU.
// Used by fpa_div_pipe, fixed_point_alu and the testbench; depends on nothing else.
package fpa_pkg;

  // Number of fraction bits in the raw operands.
  localparam int unsigned FRAC_BITS = 8;

  // Width of the scaled dividend |lhs| << FRAC_BITS, which is also the quotient width.
  localparam int unsigned NUM_W = 32 + FRAC_BITS;

  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_MUL    = 4'd2,
    CMD_DIV    = 4'd3,
    CMD_LT     = 4'd4,
    CMD_GT     = 4'd5,
    CMD_LE     = 4'd6,
    CMD_GE     = 4'd7,
    CMD_EQ     = 4'd8,
    CMD_NE     = 4'd9,
    CMD_MIN    = 4'd10,
    CMD_MAX    = 4'd11,
    CMD_INC    = 4'd12,
    CMD_DEC    = 4'd13,
    CMD_TO_INT = 4'd14
  } cmd_t;

  // Everything an item needs besides the divider datapath, carried alongside it.
  typedef struct packed {
    logic [3:0]  cmd;
    logic        neg;    // operand signs differ
    logic        a_neg;  // left operand is negative
    logic        dz;     // right operand is zero
    logic [31:0] res;    // result of the simple commands
    logic        cmp;
    logic        err;
    logic [32:0] mmag;   // rounded product magnitude; 2^33 or more clamped to 2^32
  } side_t;

endpackage

/* hw/rtl/fpa_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Carries an fpa_pkg::side_t payload alongside; depends on fpa_pkg.
module fpa_div_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [fpa_pkg::NUM_W-1:0]    in_num,
  input  logic [31:0]                  in_den,
  input  fpa_pkg::side_t               in_side,
  output logic                         out_vld,
  output logic [fpa_pkg::NUM_W-1:0]    out_quo,
  output logic [31:0]                  out_rem,
  output logic [31:0]                  out_den,
  output fpa_pkg::side_t               out_side
);

  logic                         vld_r  [fpa_pkg::NUM_W];
  logic [fpa_pkg::NUM_W-1:0]    nq_r   [fpa_pkg::NUM_W];
  logic [31:0]                  rem_r  [fpa_pkg::NUM_W];
  logic [31:0]                  den_r  [fpa_pkg::NUM_W];
  fpa_pkg::side_t               side_r [fpa_pkg::NUM_W];

  for (genvar k = 0; k < fpa_pkg::NUM_W; k++) begin : g_stage
    logic                       vld_p;
    logic [fpa_pkg::NUM_W-1:0]  nq_p;
    logic [31:0]                rem_p;
    logic [31:0]                den_p;
    fpa_pkg::side_t             side_p;
    logic [32:0]                trial;
    logic                       ge;
    logic [31:0]                rem_nxt;
    logic [fpa_pkg::NUM_W-1:0]  nq_nxt;

    if (k == 0) begin : g_first
      assign vld_p  = in_vld;
      assign nq_p   = in_num;
      assign rem_p  = 32'd0;
      assign den_p  = in_den;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[k-1];
      assign nq_p   = nq_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign den_p  = den_r[k-1];
      assign side_p = side_r[k-1];
    end

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    assign trial   = {rem_p, nq_p[fpa_pkg::NUM_W-1]};
    assign ge      = trial >= {1'b0, den_p};
    assign rem_nxt = ge ? 32'(trial - {1'b0, den_p}) : trial[31:0];
    assign nq_nxt  = {nq_p[fpa_pkg::NUM_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        nq_r[k]   <= nq_nxt;
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_p;
        side_r[k] <= side_p;
      end
    end
  end

  assign out_vld  = vld_r[fpa_pkg::NUM_W-1];
  assign out_quo  = nq_r[fpa_pkg::NUM_W-1];
  assign out_rem  = rem_r[fpa_pkg::NUM_W-1];
  assign out_den  = den_r[fpa_pkg::NUM_W-1];
  assign out_side = side_r[fpa_pkg::NUM_W-1];

  // A finished remainder is always below a nonzero divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[fpa_pkg::NUM_W-1] && den_r[fpa_pkg::NUM_W-1] != 32'd0)
      |-> (rem_r[fpa_pkg::NUM_W-1] < den_r[fpa_pkg::NUM_W-1]))
    else $error("divider remainder not below divisor");

endmodule

/* hw/rtl/fixed_point_alu.sv */
// Path: an item passes the stage 0, 1 and 2 registers, the divider stages, the f1 and f2
// quotient rounding registers and the output register before it reaches out_tvalid.
// Throughput: one item per cycle; the divider spends one register stage per quotient bit.
// The whole pipeline advances together and holds while a result waits on out_tready.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
// Top level of the fixed-point ALU; depends on fpa_pkg and fpa_div_pipe.
module fixed_point_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] lhs_raw, [63:32] rhs_raw
  input  logic [3:0]  in_tuser,   // [3:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_raw
  output logic [1:0]  out_tuser   // [0] compare_true, [1] error_flag
);

  localparam int unsigned NW = fpa_pkg::NUM_W;

  logic adv;

  // Stage 0: operands and magnitudes.
  logic               s0_vld_r;
  logic [3:0]         s0_cmd_r;
  logic signed [31:0] s0_a_r;
  logic signed [31:0] s0_b_r;
  logic [31:0]        s0_ma_r;
  logic [31:0]        s0_mb_r;

  // Stage 1: simple results and partial products.
  logic               s1_vld_r;
  fpa_pkg::side_t     s1_side_r;
  fpa_pkg::side_t     s1_side_nxt;
  logic [31:0]        s1_ma_r;
  logic [31:0]        s1_mb_r;
  logic [47:0]        s1_pl_r;
  logic [47:0]        s1_ph_r;

  // Stage 2: full product.
  logic               s2_vld_r;
  fpa_pkg::side_t     s2_side_r;
  logic [31:0]        s2_ma_r;
  logic [31:0]        s2_mb_r;
  logic [63:0]        s2_p_r;

  logic [63:0]        prod_rnd;
  logic [63:0]        prod_q;
  fpa_pkg::side_t     div_side_in;

  logic               dv_vld;
  logic [NW-1:0]      dv_quo;
  logic [31:0]        dv_rem;
  logic [31:0]        dv_den;
  fpa_pkg::side_t     dv_side;

  logic               f1_vld_r;
  logic [NW-1:0]      f1_q_r;
  logic               f1_rnd_r;
  fpa_pkg::side_t     f1_side_r;

  logic               f2_vld_r;
  logic [32:0]        f2_dmag_r;
  logic [32:0]        f2_dmag_nxt;
  logic [NW:0]        f2_qr;
  fpa_pkg::side_t     f2_side_r;

  logic               out_valid_r;
  logic [31:0]        out_tdata_r;
  logic [1:0]         out_tuser_r;
  logic [31:0]        out_res_nxt;
  logic               out_err_nxt;

  logic [32:0]        sum33;
  logic [32:0]        dif33;
  logic [32:0]        inc33;
  logic [32:0]        dec33;
  logic [32:0]        clamp_o;
  logic [32:0]        sat_o;

  // Returns {err, value} for a 33-bit exact sum clamped to 32 bits.
  function automatic logic [32:0] clamp33(input logic [32:0] v);
    logic [32:0] r;
    if (v[32] != v[31]) begin
      r = {1'b1, (v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Applies a sign to a magnitude with saturation; returns {err, value}.
  function automatic logic [32:0] sat_sign(input logic neg, input logic [32:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 33'h0_8000_0000) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, 32'((~mag[31:0]) + 32'd1)};
      end
    end else begin
      if (mag > 33'h0_7FFF_FFFF) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, mag[31:0]};
      end
    end
    return r;
  endfunction

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // ---------------------------------------------------------------- stage 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_cmd_r <= in_tuser;
      s0_a_r   <= in_tdata[31:0];
      s0_b_r   <= in_tdata[63:32];
      s0_ma_r  <= in_tdata[31] ? 32'((~in_tdata[31:0]) + 32'd1) : in_tdata[31:0];
      s0_mb_r  <= in_tdata[63] ? 32'((~in_tdata[63:32]) + 32'd1) : in_tdata[63:32];
    end
  end

  // ---------------------------------------------------------------- stage 1
  assign sum33 = {s0_a_r[31], s0_a_r} + {s0_b_r[31], s0_b_r};
  assign dif33 = {s0_a_r[31], s0_a_r} - {s0_b_r[31], s0_b_r};
  assign inc33 = {s0_a_r[31], s0_a_r} + 33'd1;
  assign dec33 = {s0_a_r[31], s0_a_r} - 33'd1;

  always_comb begin
    s1_side_nxt       = '0;
    s1_side_nxt.cmd   = s0_cmd_r;
    s1_side_nxt.neg   = s0_a_r[31] ^ s0_b_r[31];
    s1_side_nxt.a_neg = s0_a_r[31];
    s1_side_nxt.dz    = (s0_mb_r == 32'd0);
    clamp_o           = '0;
    case (s0_cmd_r)
      fpa_pkg::CMD_ADD: clamp_o = clamp33(sum33);
      fpa_pkg::CMD_SUB: clamp_o = clamp33(dif33);
      fpa_pkg::CMD_INC: clamp_o = clamp33(inc33);
      fpa_pkg::CMD_DEC: clamp_o = clamp33(dec33);
      default:          clamp_o = '0;
    endcase
    case (s0_cmd_r)
      fpa_pkg::CMD_ADD,
      fpa_pkg::CMD_SUB,
      fpa_pkg::CMD_INC,
      fpa_pkg::CMD_DEC: begin
        s1_side_nxt.res = clamp_o[31:0];
        s1_side_nxt.err = clamp_o[32];
      end
      fpa_pkg::CMD_LT: s1_side_nxt.cmp = (s0_a_r <  s0_b_r);
      fpa_pkg::CMD_GT: s1_side_nxt.cmp = (s0_a_r >  s0_b_r);
      fpa_pkg::CMD_LE: s1_side_nxt.cmp = (s0_a_r <= s0_b_r);
      fpa_pkg::CMD_GE: s1_side_nxt.cmp = (s0_a_r >= s0_b_r);
      fpa_pkg::CMD_EQ: s1_side_nxt.cmp = (s0_a_r == s0_b_r);
      fpa_pkg::CMD_NE: s1_side_nxt.cmp = (s0_a_r != s0_b_r);
      fpa_pkg::CMD_MIN: s1_side_nxt.res = (s0_a_r < s0_b_r) ? s0_a_r : s0_b_r;
      fpa_pkg::CMD_MAX: s1_side_nxt.res = (s0_a_r > s0_b_r) ? s0_a_r : s0_b_r;
      fpa_pkg::CMD_TO_INT: s1_side_nxt.res = 32'(s0_a_r >>> fpa_pkg::FRAC_BITS);
      default: s1_side_nxt.res = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r <= s1_side_nxt;
      s1_ma_r   <= s0_ma_r;
      s1_mb_r   <= s0_mb_r;
      s1_pl_r   <= s0_ma_r * s0_mb_r[15:0];
      s1_ph_r   <= s0_ma_r * s0_mb_r[31:16];
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r <= s1_side_r;
      s2_ma_r   <= s1_ma_r;
      s2_mb_r   <= s1_mb_r;
      s2_p_r    <= {16'd0, s1_pl_r} + {s1_ph_r, 16'd0};
    end
  end

  // Round the product to nearest, ties away from zero; any magnitude of 2^32 or
  // more saturates either way, so 2^33 and up is clamped to 2^32 to keep the word narrow.
  assign prod_rnd = s2_p_r + (64'd1 << (fpa_pkg::FRAC_BITS - 1));
  assign prod_q   = prod_rnd >> fpa_pkg::FRAC_BITS;

  always_comb begin
    div_side_in      = s2_side_r;
    div_side_in.mmag = (|prod_q[63:33]) ? {1'b1, 32'd0} : prod_q[32:0];
  end

  fpa_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (s2_vld_r),
    .in_num   ({s2_ma_r, {fpa_pkg::FRAC_BITS{1'b0}}}),
    .in_den   (s2_mb_r),
    .in_side  (div_side_in),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_rem  (dv_rem),
    .out_den  (dv_den),
    .out_side (dv_side)
  );

  // ---------------------------------------------------------------- quotient rounding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= dv_vld;
      f2_vld_r <= f1_vld_r;
    end
  end

  // Round up when the remainder is at least half the divisor.
  assign f2_qr       = {1'b0, f1_q_r} + {{NW{1'b0}}, f1_rnd_r};
  assign f2_dmag_nxt = (|f2_qr[NW:33]) ? {1'b1, 32'd0} : f2_qr[32:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_q_r    <= dv_quo;
      f1_rnd_r  <= {dv_rem, 1'b0} >= {1'b0, dv_den};
      f1_side_r <= dv_side;
      f2_dmag_r <= f2_dmag_nxt;
      f2_side_r <= f1_side_r;
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    sat_o       = '0;
    out_res_nxt = f2_side_r.res;
    out_err_nxt = f2_side_r.err;
    case (f2_side_r.cmd)
      fpa_pkg::CMD_MUL: begin
        sat_o       = sat_sign(f2_side_r.neg, f2_side_r.mmag);
        out_res_nxt = sat_o[31:0];
        out_err_nxt = sat_o[32];
      end
      fpa_pkg::CMD_DIV: begin
        sat_o = sat_sign(f2_side_r.neg, f2_dmag_r);
        if (f2_side_r.dz) begin
          out_res_nxt = f2_side_r.a_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          out_err_nxt = 1'b1;
        end else begin
          out_res_nxt = sat_o[31:0];
          out_err_nxt = sat_o[32];
        end
      end
      default: begin
        out_res_nxt = f2_side_r.res;
        out_err_nxt = f2_side_r.err;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= out_res_nxt;
      out_tuser_r <= {out_err_nxt, f2_side_r.cmp};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // A true comparison never carries an error flag.
  a_cmp_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser_r[0]) |-> !out_tuser_r[1])
    else $error("comparison result carries an error flag");

  // A true comparison reports a zero result word.
  a_cmp_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser_r[0]) |-> (out_tdata_r == 32'd0))
    else $error("comparison result word not zero");

  // While the pipeline is held, the front stage keeps its item.
  a_hold_front: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s0_vld_r))
    else $error("front stage changed during a stall");

  // While the pipeline is held, a finished division keeps its quotient.
  a_hold_quo: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && f1_vld_r) |=> ($stable(f1_q_r) && $stable(f1_rnd_r)))
    else $error("quotient changed during a stall");

endmodule

/* sim/fixed_point_alu_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for fixed_point_alu: streams operations in random bursts and
// compares every result transfer against an in-bench fixed-point predictor.
// Depends on fpa_pkg and fixed_point_alu only.
module fixed_point_alu_tb;

  localparam logic [3:0]  CMD_UNUSED   = 4'd15;
  localparam logic [31:0] RAW_MAX_BITS = 32'h7FFF_FFFF;
  localparam logic [31:0] RAW_MIN_BITS = 32'h8000_0000;
  localparam logic [31:0] ONE_FIX      = 32'd1 << fpa_pkg::FRAC_BITS;
  localparam logic [31:0] HALF_FIX     = 32'd1 << (fpa_pkg::FRAC_BITS - 1);
  localparam longint RAW_MAX = 64'sd2147483647;
  localparam longint RAW_MIN = -64'sd2147483648;
  localparam longint unsigned ROUND_HALF = 64'd1 << (fpa_pkg::FRAC_BITS - 1);
  localparam int RANDOM_OPS   = 500;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 60;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [31:0] res;
    logic        cmp;
    logic        err;
  } alu_result_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_PERIODIC
  } ready_mode_t;

  class alu_scoreboard;
    alu_result_t pending_results[$];
    int          fail_count;

    function alu_result_t saturate_exact(longint v);
      alu_result_t r;
      r = '0;
      if (v > RAW_MAX) begin
        v = RAW_MAX;
        r.err = 1'b1;
      end else if (v < RAW_MIN) begin
        v = RAW_MIN;
        r.err = 1'b1;
      end
      r.res = v[31:0];
      return r;
    endfunction

    function alu_result_t saturate_signed_mag(logic neg, longint unsigned mag);
      alu_result_t r;
      longint v;
      r = '0;
      if (neg) begin
        if (mag > 64'd2147483648) begin
          v = RAW_MIN;
          r.err = 1'b1;
        end else begin
          v = -longint'(mag);
        end
      end else if (mag > 64'd2147483647) begin
        v = RAW_MAX;
        r.err = 1'b1;
      end else begin
        v = longint'(mag);
      end
      r.res = v[31:0];
      return r;
    endfunction

    function alu_result_t predict_alu_result(logic [3:0] cmd, logic signed [31:0] lhs,
                                             logic signed [31:0] rhs);
      alu_result_t r;
      longint a_val, b_val;
      longint unsigned a_mag, b_mag, prod, quot, num;
      logic neg;
      r = '0;
      a_val = lhs;
      b_val = rhs;
      a_mag = (a_val < 0) ? -a_val : a_val;
      b_mag = (b_val < 0) ? -b_val : b_val;
      neg = (a_val < 0) != (b_val < 0);
      case (cmd)
        fpa_pkg::CMD_ADD: r = saturate_exact(a_val + b_val);
        fpa_pkg::CMD_SUB: r = saturate_exact(a_val - b_val);
        fpa_pkg::CMD_MUL: begin
          prod = a_mag * b_mag;
          quot = (prod + ROUND_HALF) >> fpa_pkg::FRAC_BITS;
          r = saturate_signed_mag(neg, quot);
        end
        fpa_pkg::CMD_DIV: begin
          if (b_mag == 0) begin
            r.err = 1'b1;
            r.res = (a_val < 0) ? RAW_MIN_BITS : RAW_MAX_BITS;
          end else begin
            // Rounding to nearest with ties away from zero on the magnitudes.
            num = a_mag << fpa_pkg::FRAC_BITS;
            quot = (64'd2 * num + b_mag) / (64'd2 * b_mag);
            r = saturate_signed_mag(neg, quot);
          end
        end
        fpa_pkg::CMD_LT:     r.cmp = a_val < b_val;
        fpa_pkg::CMD_GT:     r.cmp = a_val > b_val;
        fpa_pkg::CMD_LE:     r.cmp = a_val <= b_val;
        fpa_pkg::CMD_GE:     r.cmp = a_val >= b_val;
        fpa_pkg::CMD_EQ:     r.cmp = a_val == b_val;
        fpa_pkg::CMD_NE:     r.cmp = a_val != b_val;
        fpa_pkg::CMD_MIN:    r.res = (a_val < b_val) ? lhs : rhs;
        fpa_pkg::CMD_MAX:    r.res = (a_val > b_val) ? lhs : rhs;
        fpa_pkg::CMD_INC:    r = saturate_exact(a_val + 1);
        fpa_pkg::CMD_DEC:    r = saturate_exact(a_val - 1);
        fpa_pkg::CMD_TO_INT: r.res = lhs >>> fpa_pkg::FRAC_BITS;
        default: ;
      endcase
      return r;
    endfunction

    function void note_operation(logic [3:0] cmd, logic [31:0] lhs, logic [31:0] rhs);
      pending_results.push_back(predict_alu_result(cmd, lhs, rhs));
    endfunction

    function void check_result(logic [31:0] res, logic [1:0] flags);
      alu_result_t got, want;
      got.res = res;
      got.cmp = flags[0];
      got.err = flags[1];
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result transfer with nothing outstanding: res=%h cmp=%b err=%b",
                   $realtime, got.res, got.cmp, got.err);
        return;
      end
      want = pending_results.pop_front();
      if (got != want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: mismatch: res exp %h got %h, cmp exp %b got %b, err exp %b got %b",
                   $realtime, want.res, got.res, want.cmp, got.cmp, want.err, got.err);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [3:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  alu_scoreboard sb;
  logic          long_hold_req = 1'b0;
  int            cycle_count = 0;

  fixed_point_alu u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Transfers are taken at the rising edge; the block's outputs still hold their pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_operation(in_tuser, in_tdata[31:0], in_tdata[63:32]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tuser);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: a random ready pattern that changes now and then, plus long hold-offs on request.
  initial begin
    ready_mode_t ready_mode;
    int mode_left;
    int hold_left;
    int phase;
    ready_mode = READY_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(3, 0));
        mode_left = $urandom_range(200, 20);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (ready_mode)
          READY_ALWAYS: out_tready <= 1'b1;
          READY_COIN:   out_tready <= 1'($urandom_range(1, 0));
          READY_MOSTLY: out_tready <= ($urandom_range(9, 0) != 0);
          default:      out_tready <= (phase % 4) != 0;
        endcase
      end
    end
  end

  task automatic send_op(input logic [3:0] cmd, input logic [31:0] lhs,
                         input logic [31:0] rhs);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {rhs, lhs};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_gap(input int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_all_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    case ($urandom_range(5, 0))
      0: v = $urandom_range(4095, 0) - 32'd2048;
      1: begin
        case ($urandom_range(4, 0))
          0: v = RAW_MAX_BITS;
          1: v = RAW_MIN_BITS;
          2: v = '0;
          3: v = ONE_FIX;
          default: v = '1;
        endcase
      end
      2: begin
        v = 32'd1 << $urandom_range(30, 0);
        v = v + $urandom_range(3, 0) - 32'd1;
        if ($urandom_range(1, 0)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    int burst_left;
    int sent;
    logic [3:0] cmd;
    logic [31:0] lhs, rhs;
    sb = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Boundaries: overflow at both ends, rounding ties, division by zero, equal operands.
    send_op(fpa_pkg::CMD_ADD,    RAW_MAX_BITS, 32'd1);
    send_op(fpa_pkg::CMD_ADD,    RAW_MIN_BITS, '1);
    send_op(fpa_pkg::CMD_SUB,    RAW_MIN_BITS, 32'd1);
    send_op(fpa_pkg::CMD_MUL,    RAW_MAX_BITS, RAW_MAX_BITS);
    send_op(fpa_pkg::CMD_MUL,    32'd1, HALF_FIX);
    send_op(fpa_pkg::CMD_MUL,    '1, HALF_FIX);
    send_op(fpa_pkg::CMD_MUL,    RAW_MIN_BITS, -ONE_FIX);
    send_op(fpa_pkg::CMD_MUL,    RAW_MIN_BITS, ONE_FIX);
    send_op(fpa_pkg::CMD_DIV,    32'd5, '0);
    send_op(fpa_pkg::CMD_DIV,    -32'd5, '0);
    send_op(fpa_pkg::CMD_DIV,    '0, '0);
    send_op(fpa_pkg::CMD_DIV,    32'd1, ONE_FIX << 1);
    send_op(fpa_pkg::CMD_DIV,    RAW_MAX_BITS, 32'd1);
    send_op(fpa_pkg::CMD_DIV,    RAW_MIN_BITS, -ONE_FIX);
    send_op(fpa_pkg::CMD_LT,     RAW_MIN_BITS, RAW_MAX_BITS);
    send_op(fpa_pkg::CMD_GT,     RAW_MAX_BITS, RAW_MIN_BITS);
    send_op(fpa_pkg::CMD_LE,     32'd7, 32'd7);
    send_op(fpa_pkg::CMD_GE,     -32'd7, 32'd7);
    send_op(fpa_pkg::CMD_EQ,     32'd7, 32'd7);
    send_op(fpa_pkg::CMD_NE,     32'd7, 32'd7);
    send_op(fpa_pkg::CMD_MIN,    -32'd3, -32'd3);
    send_op(fpa_pkg::CMD_MAX,    RAW_MIN_BITS, RAW_MAX_BITS);
    send_op(fpa_pkg::CMD_INC,    RAW_MAX_BITS, $urandom);
    send_op(fpa_pkg::CMD_DEC,    RAW_MIN_BITS, $urandom);
    send_op(fpa_pkg::CMD_TO_INT, '1, $urandom);
    send_op(fpa_pkg::CMD_TO_INT, RAW_MAX_BITS, $urandom);
    send_op(CMD_UNUSED,          $urandom, $urandom);
    idle_gap(1);
    wait_all_results();

    burst_left = 0;
    for (sent = 0; sent < RANDOM_OPS; sent++) begin
      if (sent == 150) begin
        // Stall the result side for a long stretch while operations keep coming.
        long_hold_req = 1'b1;
        burst_left = 120;
      end else if (sent == 320) begin
        idle_gap(1);
        wait_all_results();
        burst_left = 0;
      end
      if (burst_left == 0) begin
        if ($urandom_range(3, 0) != 0) idle_gap($urandom_range(6, 1));
        burst_left = $urandom_range(24, 1);
      end
      burst_left--;

      if ($urandom_range(63, 0) == 0) cmd = CMD_UNUSED;
      else cmd = 4'($urandom_range(int'(fpa_pkg::CMD_TO_INT), int'(fpa_pkg::CMD_ADD)));
      lhs = random_operand();
      case ($urandom_range(19, 0))
        0, 1, 2: rhs = lhs;
        3:       rhs = '0;
        default: rhs = random_operand();
      endcase
      send_op(cmd, lhs, rhs);
    end

    idle_gap(1);
    wait_all_results();
    repeat (SETTLE) @(posedge clk);

    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
